// ===== hw/rtl/mcfp_pkg.sv =====
`timescale 1ns / 1ps
package mcfp_pkg;

  localparam int unsigned PosCodeBits = 16;
  localparam int unsigned OthCodeBits = 12;
  localparam int unsigned MaxCodeBits = 16;
  localparam int unsigned NumLanes    = 5;
  localparam int unsigned NumRegs     = 5;
  localparam int unsigned LimW        = 31;

  typedef enum logic [1:0] {
    OP_MOTION  = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_SETZERO = 2'd3
  } op_e;

  localparam logic [2:0] REG_POS = 3'd0;
  localparam logic [2:0] REG_VEL = 3'd1;
  localparam logic [2:0] REG_TRQ = 3'd2;
  localparam logic [2:0] REG_KP  = 3'd3;
  localparam logic [2:0] REG_KD  = 3'd4;

  localparam logic [7:0] CMD_ENABLE  = 8'hFC;
  localparam logic [7:0] CMD_SETZERO = 8'hFE;
  localparam logic [7:0] CMD_DISABLE = 8'hFD;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  localparam logic [31:0] GAIN_ONE = 32'h0001_0000;

  localparam logic [LimW-1:0] RST_POS = 31'd819200;
  localparam logic [LimW-1:0] RST_VEL = 31'd3276800;
  localparam logic [LimW-1:0] RST_TRQ = 31'd1179648;
  localparam logic [LimW-1:0] RST_KP  = 31'd32768000;
  localparam logic [LimW-1:0] RST_KD  = 31'd327680;

  // lane order: position, velocity, stiffness, damping, torque
  localparam int unsigned LnPos = 0;
  localparam int unsigned LnVel = 1;
  localparam int unsigned LnKp  = 2;
  localparam int unsigned LnKd  = 3;
  localparam int unsigned LnTrq = 4;

  typedef struct packed {
    logic [7:0]            id;
    logic                  last;
    logic                  fixed;
    logic [7:0]            cmd;
    logic [4:0][31:0]      val;
  } entry_t;

  typedef struct packed {
    logic [31:0]            rem;
    logic [MaxCodeBits-1:0] quo;
    logic                   sat;
    logic                   zro;
  } lane_t;

  typedef struct packed {
    logic [7:0]       id;
    logic             last;
    logic             fixed;
    logic [7:0]       cmd;
    lane_t [4:0]      lanes;
  } pipe_t;

endpackage

// ===== hw/rtl/mcfp_if.sv =====
`timescale 1ns / 1ps
interface mcfp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  driver_address;
  logic signed [31:0] target_position;
  logic signed [31:0] target_velocity;
  logic signed [31:0] stiffness_gain;
  logic signed [31:0] damping_gain;
  logic signed [31:0] feedforward_torque;

  modport source (output valid, operation, driver_address, target_position,
                  target_velocity, stiffness_gain, damping_gain, feedforward_torque,
                  input ready);
  modport sink (input valid, operation, driver_address, target_position,
                target_velocity, stiffness_gain, damping_gain, feedforward_torque,
                output ready);
endinterface

interface mcfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_id;
  logic [31:0] frame_bytes_high;
  logic [31:0] frame_bytes_low;
  logic        last_frame;

  modport source (output valid, frame_id, frame_bytes_high, frame_bytes_low, last_frame,
                  input ready);
  modport sink (input valid, frame_id, frame_bytes_high, frame_bytes_low, last_frame,
                output ready);
endinterface

// ===== hw/rtl/mcfp_clamp.sv =====
`timescale 1ns / 1ps
module mcfp_clamp
  import mcfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  entry_t           entry_i,
  input  logic [4:0][31:0] span_i,
  output logic             valid_o,
  output pipe_t            pipe_o
);

  logic  valid_q;
  pipe_t pipe_q, pipe_d;

  always_comb begin
    logic signed [32:0] xs;
    logic signed [32:0] lim;
    logic [31:0]        num;
    pipe_d.id    = entry_i.id;
    pipe_d.last  = entry_i.last;
    pipe_d.fixed = entry_i.fixed;
    pipe_d.cmd   = entry_i.cmd;
    for (int l = 0; l < NumLanes; l++) begin
      xs = {entry_i.val[l][31], entry_i.val[l]};
      if (l == LnKp || l == LnKd) begin
        lim = {1'b0, span_i[l]};
        if (xs < 0) num = '0;
        else if (xs > lim) num = span_i[l];
        else num = entry_i.val[l];
      end else begin
        // symmetric span is 2L, so L is span >> 1
        lim = {2'b00, span_i[l][31:1]};
        if (xs < -lim) num = '0;
        else if (xs > lim) num = span_i[l];
        else num = 32'(xs + lim);
      end
      pipe_d.lanes[l].rem = num;
      pipe_d.lanes[l].quo = '0;
      pipe_d.lanes[l].zro = (span_i[l] == '0);
      pipe_d.lanes[l].sat = (num == span_i[l]) && (span_i[l] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ===== hw/rtl/mcfp_div_stage.sv =====
`timescale 1ns / 1ps
module mcfp_div_stage
  import mcfp_pkg::*;
#(
  parameter int unsigned STEP     = 0,
  parameter int unsigned POS_BITS = PosCodeBits,
  parameter int unsigned OTH_BITS = OthCodeBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pipe_t            pipe_i,
  input  logic [4:0][31:0] span_i,
  output logic             valid_o,
  output pipe_t            pipe_o
);

  logic  valid_q;
  pipe_t pipe_q, pipe_d;

  // one restoring-division bit per lane, for each lane whose code width exceeds STEP
  always_comb begin
    logic [32:0] t;
    pipe_d = pipe_i;
    for (int l = 0; l < NumLanes; l++) begin
      t = {pipe_i.lanes[l].rem, 1'b0};
      if (STEP < ((l == LnPos) ? POS_BITS : OTH_BITS)) begin
        if (t >= {1'b0, span_i[l]}) begin
          pipe_d.lanes[l].rem = 32'(t - {1'b0, span_i[l]});
          pipe_d.lanes[l].quo = {pipe_i.lanes[l].quo[MaxCodeBits-2:0], 1'b1};
        end else begin
          pipe_d.lanes[l].rem = t[31:0];
          pipe_d.lanes[l].quo = {pipe_i.lanes[l].quo[MaxCodeBits-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ===== hw/rtl/motor_command_frame_packer_top.sv =====
`timescale 1ns / 1ps
// Pipeline: clamp stage, one division bit per stage, pack register; the whole pipe
// stalls while the output beat waits.
// Throughput: one frame per cycle unless the output stalls; a disable beat yields two
// frames and holds the input while its fixed frame enters the pipe.
// Reset: asynchronous, active low; clears valid bits and loads the default limits.
module motor_command_frame_packer_top
  import mcfp_pkg::*;
#(
  parameter int unsigned POS_BITS = PosCodeBits,
  parameter int unsigned OTH_BITS = OthCodeBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mcfp_in_if.sink            in_ch,
  mcfp_out_if.source         out_ch,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [LimW-1:0]    cfg_data_i
);

  localparam int unsigned NStep = (POS_BITS > OTH_BITS) ? POS_BITS : OTH_BITS;

  logic [NumRegs-1:0][LimW-1:0] lim_q;
  logic [4:0][31:0]             span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q[REG_POS] <= RST_POS;
      lim_q[REG_VEL] <= RST_VEL;
      lim_q[REG_TRQ] <= RST_TRQ;
      lim_q[REG_KP]  <= RST_KP;
      lim_q[REG_KD]  <= RST_KD;
    end else if (cfg_we_i && (cfg_idx_i <= REG_KD)) begin
      lim_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign span[LnPos] = {lim_q[REG_POS], 1'b0};
  assign span[LnVel] = {lim_q[REG_VEL], 1'b0};
  assign span[LnTrq] = {lim_q[REG_TRQ], 1'b0};
  assign span[LnKp]  = {1'b0, lim_q[REG_KP]};
  assign span[LnKd]  = {1'b0, lim_q[REG_KD]};

  // pipeline advance
  logic out_vld_q;
  logic en;
  assign en = !out_vld_q || out_ch.ready;

  // entry: a disable beat takes two slots, the fixed frame follows from pend_q
  logic       pend_q;
  logic [7:0] pend_id_q;
  logic       acc;
  logic       ent_vld;
  entry_t     ent;

  assign in_ch.ready = en && !pend_q;
  assign acc         = in_ch.valid && in_ch.ready;
  assign ent_vld     = pend_q || acc;

  always_comb begin
    ent.id    = in_ch.driver_address;
    ent.last  = 1'b1;
    ent.fixed = 1'b0;
    ent.cmd   = CMD_ENABLE;
    ent.val[LnPos] = in_ch.target_position;
    ent.val[LnVel] = in_ch.target_velocity;
    ent.val[LnKp]  = in_ch.stiffness_gain;
    ent.val[LnKd]  = in_ch.damping_gain;
    ent.val[LnTrq] = in_ch.feedforward_torque;
    if (pend_q) begin
      ent.id    = pend_id_q;
      ent.fixed = 1'b1;
      ent.cmd   = CMD_DISABLE;
    end else begin
      unique case (op_e'(in_ch.operation))
        OP_MOTION: ;
        OP_ENABLE: begin
          ent.fixed = 1'b1;
          ent.cmd   = CMD_ENABLE;
        end
        OP_SETZERO: begin
          ent.fixed = 1'b1;
          ent.cmd   = CMD_SETZERO;
        end
        OP_DISABLE: begin
          ent.last       = 1'b0;
          ent.val[LnPos] = '0;
          ent.val[LnVel] = '0;
          ent.val[LnKp]  = GAIN_ONE;
          ent.val[LnKd]  = GAIN_ONE;
          ent.val[LnTrq] = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (en) begin
      pend_q <= acc && (op_e'(in_ch.operation) == OP_DISABLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_id_q <= in_ch.driver_address;
    end
  end

  logic  vld [NStep+1];
  pipe_t stg [NStep+1];

  mcfp_clamp u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ent_vld),
    .entry_i (ent),
    .span_i  (span),
    .valid_o (vld[0]),
    .pipe_o  (stg[0])
  );

  for (genvar s = 0; s < NStep; s++) begin : g_div
    mcfp_div_stage #(
      .STEP     (s),
      .POS_BITS (POS_BITS),
      .OTH_BITS (OTH_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[s]),
      .pipe_i  (stg[s]),
      .span_i  (span),
      .valid_o (vld[s+1]),
      .pipe_o  (stg[s+1])
    );
  end

  // pack
  pipe_t                  fin;
  logic [4:0][15:0]       code;
  logic [63:0]            frame_d;
  logic [31:0]            hi_q, lo_q;
  logic [7:0]             id_q;
  logic                   last_q;

  assign fin = stg[NStep];

  always_comb begin
    logic [15:0] full;
    for (int l = 0; l < NumLanes; l++) begin
      full = (l == LnPos) ? 16'((32'd1 << POS_BITS) - 32'd1)
                          : 16'((32'd1 << OTH_BITS) - 32'd1);
      if (fin.lanes[l].zro) code[l] = '0;
      else if (fin.lanes[l].sat) code[l] = full;
      else code[l] = fin.lanes[l].quo & full;
    end
    if (fin.fixed) begin
      frame_d = {{7{FILL_BYTE}}, fin.cmd};
    end else begin
      frame_d = {code[LnPos], code[LnVel][11:0], code[LnKp][11:0],
                 code[LnKd][11:0], code[LnTrq][11:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NStep];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hi_q   <= frame_d[63:32];
      lo_q   <= frame_d[31:0];
      id_q   <= fin.id;
      last_q <= fin.last;
    end
  end

  assign out_ch.valid            = out_vld_q;
  assign out_ch.frame_id         = id_q;
  assign out_ch.frame_bytes_high = hi_q;
  assign out_ch.frame_bytes_low  = lo_q;
  assign out_ch.last_frame       = last_q;

  // a disable beat always queues its fixed frame for the next slot
  a_disable_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (in_ch.operation == OP_DISABLE)) |=> pend_q)
    else $error("disable beat did not queue fixed frame");

  a_pend_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && en) |=> !pend_q)
    else $error("pending fixed frame not issued");

  // the only non-last frame is the zero motion frame, never a fixed pattern
  a_nonlast_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !last_q) |-> (hi_q != {4{FILL_BYTE}}))
    else $error("non-last beat carries a fixed frame");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import mcfp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = REG_POS;
  logic [LimW-1:0] cfg_data_i = '0;

  mcfp_in_if in_ch ();
  mcfp_out_if out_ch ();

  motor_command_frame_packer_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  typedef struct {
    logic [7:0]  id;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        last;
  } frame_t;

  typedef struct {
    op_e         op;
    logic [7:0]  addr;
    logic [31:0] p, v, kp, kd, t;
    bit          typed;   // expected frame given below
    logic [31:0] ehi, elo;
  } row_t;

  frame_t pending_frames[$];
  logic [LimW-1:0] lim_pos, lim_vel, lim_trq, lim_kp, lim_kd;
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  int hold_off = 0;
  bit driving_done = 0;

  function automatic logic [15:0] scale(longint num, longint span, int bits);
    longint c;
    if (span == 0) return '0;
    c = (num << bits) / span;
    if (c >= (longint'(1) << bits)) c = (longint'(1) << bits) - 1;
    return c[15:0];
  endfunction

  function automatic logic [15:0] sym_code(logic [31:0] raw, logic [LimW-1:0] lr, int bits);
    longint x, l;
    x = longint'($signed(raw));
    l = longint'(lr);
    if (x < -l) x = -l;
    if (x > l) x = l;
    return scale(x + l, 2 * l, bits);
  endfunction

  function automatic logic [15:0] gain_code(logic [31:0] raw, logic [LimW-1:0] lr);
    longint x, l;
    x = longint'($signed(raw));
    l = longint'(lr);
    if (x < 0) x = 0;
    if (x > l) x = l;
    return scale(x, l, OthCodeBits);
  endfunction

  function automatic logic [63:0] motion_word(logic [31:0] p, v, kp, kd, t);
    logic [15:0] pc, vc, kpc, kdc, tc;
    pc  = sym_code(p, lim_pos, PosCodeBits);
    vc  = sym_code(v, lim_vel, OthCodeBits);
    kpc = gain_code(kp, lim_kp);
    kdc = gain_code(kd, lim_kd);
    tc  = sym_code(t, lim_trq, OthCodeBits);
    return {pc, vc[11:0], kpc[11:0], kdc[11:0], tc[11:0]};
  endfunction

  function automatic logic [63:0] fixed_word(logic [7:0] cmd);
    return {{7{FILL_BYTE}}, cmd};
  endfunction

  task automatic push_frame(logic [7:0] id, logic [63:0] w, logic last);
    frame_t f;
    f.id = id; f.hi = w[63:32]; f.lo = w[31:0]; f.last = last;
    pending_frames.push_back(f);
  endtask

  task automatic predict_frames(op_e op, logic [7:0] id, logic [31:0] p, v, kp, kd, t);
    case (op)
      OP_MOTION: push_frame(id, motion_word(p, v, kp, kd, t), 1'b1);
      OP_ENABLE: push_frame(id, fixed_word(CMD_ENABLE), 1'b1);
      OP_DISABLE: begin
        push_frame(id, motion_word('0, '0, GAIN_ONE, GAIN_ONE, '0), 1'b0);
        push_frame(id, fixed_word(CMD_DISABLE), 1'b1);
      end
      default: push_frame(id, fixed_word(CMD_SETZERO), 1'b1);
    endcase
  endtask

  task automatic write_limit(logic [2:0] idx, logic [LimW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_POS: lim_pos = val;
      REG_VEL: lim_vel = val;
      REG_TRQ: lim_trq = val;
      REG_KP:  lim_kp = val;
      default: lim_kd = val;
    endcase
  endtask

  task automatic drain_frames();
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  // one beat; valid stays high across back-to-back beats
  task automatic send_item(op_e op, logic [7:0] id, logic [31:0] p, v, kp, kd, t);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op; in_ch.driver_address <= id;
    in_ch.target_position <= p; in_ch.target_velocity <= v;
    in_ch.stiffness_gain <= kp; in_ch.damping_gain <= kd;
    in_ch.feedforward_torque <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_frames(op, id, p, v, kp, kd, t);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value(logic [LimW-1:0] lim);
    case ($urandom_range(7))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return {1'b0, lim};
      4: return -{1'b0, lim};
      default: return $urandom_range(2 * lim) - lim;
    endcase
  endfunction

  task automatic send_random(int n);
    op_e op;
    repeat (n) begin
      op = op_e'($urandom_range(9) < 6 ? OP_MOTION : $urandom_range(3));
      send_item(op, $urandom(), rand_value(lim_pos), rand_value(lim_vel),
                $urandom_range(3) == 0 ? $urandom() : $urandom_range(lim_kp),
                $urandom_range(3) == 0 ? $urandom() : $urandom_range(lim_kd),
                rand_value(lim_trq));
    end
    in_ch.valid <= 1'b0;
  endtask

  // output side
  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $error("frame with nothing expected: id %h", out_ch.frame_id);
        errors++;
      end else begin
        e = pending_frames.pop_front();
        if (out_ch.frame_id !== e.id) begin
          $error("frame_id exp %h got %h", e.id, out_ch.frame_id); errors++;
        end
        if (out_ch.frame_bytes_high !== e.hi) begin
          $error("frame_bytes_high exp %h got %h", e.hi, out_ch.frame_bytes_high);
          errors++;
        end
        if (out_ch.frame_bytes_low !== e.lo) begin
          $error("frame_bytes_low exp %h got %h", e.lo, out_ch.frame_bytes_low);
          errors++;
        end
        if (out_ch.last_frame !== e.last) begin
          $error("last_frame exp %b got %b", e.last, out_ch.last_frame); errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ch.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  row_t rows[$];

  function automatic row_t mk(op_e op, logic [7:0] a, logic [31:0] p, v, kp, kd, t,
                              bit typed = 0, logic [63:0] w = '0);
    row_t r;
    r.op = op; r.addr = a; r.p = p; r.v = v; r.kp = kp; r.kd = kd; r.t = t;
    r.typed = typed; r.ehi = w[63:32]; r.elo = w[31:0];
    return r;
  endfunction

  initial begin
    int k;
    in_ch.valid = 1'b0; in_ch.operation = OP_MOTION; in_ch.driver_address = '0;
    in_ch.target_position = '0; in_ch.target_velocity = '0; in_ch.stiffness_gain = '0;
    in_ch.damping_gain = '0; in_ch.feedforward_torque = '0;
    out_ch.ready = 1'b1;
    lim_pos = RST_POS; lim_vel = RST_VEL; lim_trq = RST_TRQ; lim_kp = RST_KP; lim_kd = RST_KD;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all minimum, all maximum (saturates to all ones), midpoint with zero gains
    rows.push_back(mk(OP_MOTION, 8'h00, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 1, 64'h0));
    rows.push_back(mk(OP_MOTION, 8'hFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF));
    rows.push_back(mk(OP_MOTION, 8'h5A, 0, 0, 0, 0, 0, 1, 64'h8000_8000_0000_0800));
    rows.push_back(mk(OP_MOTION, 8'hA5, RST_POS, -RST_VEL, RST_KP, RST_KD, -RST_TRQ));
    rows.push_back(mk(OP_MOTION, 8'h01, 32'h1234_5678, 32'hFFFF_0001, GAIN_ONE,
                      GAIN_ONE, 32'h0000_8000));
    rows.push_back(mk(OP_ENABLE, 8'h12, '1, '1, '1, '1, '1, 1, 64'hFFFF_FFFF_FFFF_FFFC));
    rows.push_back(mk(OP_SETZERO, 8'h34, 0, 0, 0, 0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFE));
    rows.push_back(mk(OP_DISABLE, 8'h56, '1, 0, '1, 0, '1));
    rows.push_back(mk(OP_DISABLE, 8'hAA, 0, '1, 0, '1, 0));
    rows.push_back(mk(OP_ENABLE, 8'h55, 32'h5555_5555, 0, 0, 0, 0, 1,
                      64'hFFFF_FFFF_FFFF_FFFC));
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        k = pending_frames.size();
        send_item(rows[i].op, rows[i].addr, rows[i].p, rows[i].v, rows[i].kp,
                  rows[i].kd, rows[i].t);
        pending_frames[k].hi = rows[i].ehi;
        pending_frames[k].lo = rows[i].elo;
      end else begin
        send_item(rows[i].op, rows[i].addr, rows[i].p, rows[i].v, rows[i].kp,
                  rows[i].kd, rows[i].t);
      end
    end
    in_ch.valid <= 1'b0;
    drain_frames();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        3: begin send_idle = 36; recv_stall = 36; end
        default: begin send_idle = $urandom_range(40); recv_stall = $urandom_range(40); end
      endcase
      // limits: extremes on some phases, random on others, reset defaults on phase 0
      case (ph)
        1: begin
          write_limit(REG_POS, 1); write_limit(REG_VEL, 1); write_limit(REG_TRQ, 1);
          write_limit(REG_KP, 1); write_limit(REG_KD, 1);
        end
        2: begin
          write_limit(REG_POS, '1); write_limit(REG_VEL, '1); write_limit(REG_TRQ, '1);
          write_limit(REG_KP, '1); write_limit(REG_KD, '1);
        end
        0: ;
        default: begin
          write_limit(REG_POS, $urandom_range(32'h7FFF_FFFF, 1));
          write_limit(REG_VEL, $urandom_range(5000, 1));
          write_limit(REG_TRQ, $urandom_range(32'h7FFF_FFFF, 1));
          write_limit(REG_KP, $urandom_range(32'h00FF_FFFF, 1));
          write_limit(REG_KD, $urandom_range(32'h7FFF_FFFF, 1));
        end
      endcase
      @(negedge clk_i);
      if (ph == 4) hold_off = 300;  // receiver blocks; input backs up
      send_random(240);
      drain_frames();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
